// ===== rtl/core/swrs_pkg.sv =====
// ----------------------------------------------------------------------------
// swrs_pkg
// Shared constants and types of the sliding-window rate shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package swrs_pkg;

  localparam int FLOWS_DEF  = 64;
  localparam int FLOW_IDX_W = 6;
  localparam int DATA_W     = 32;
  localparam int WIN_W      = 16;
  localparam int FRAME_W    = 20;
  localparam int T_W        = 26;
  localparam int PROD_W     = 64;
  localparam int DIVD_W     = 33;
  localparam int ADDR_W     = 3;

  localparam logic [FRAME_W-1:0] FRAME_RST   = 20'd5000;
  localparam logic [22:0]        US_PER_BYTE = 23'd8000000;
  localparam logic [9:0]         US_PER_MS   = 10'd1000;

  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  localparam logic REG_FRAME = 1'b0;

  typedef struct packed {
    logic                  func;
    logic                  in_table;
    logic [FLOW_IDX_W-1:0] idx;
    logic [DATA_W-1:0]     now;
    logic [DATA_W-1:0]     rmin;
    logic [DATA_W-1:0]     rmax;
    logic [DATA_W-1:0]     burst;
    logic [WIN_W-1:0]      win;
    logic [DATA_W-1:0]     queue;
    logic [DATA_W-1:0]     amin;
    logic [DATA_W-1:0]     amax;
    logic [FRAME_W-1:0]    frame;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/swrs_div.sv =====
// ----------------------------------------------------------------------------
// swrs_div
// Restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swrs_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [swrs_pkg::PROD_W-1:0]      dividend_i,
  input  wire logic [swrs_pkg::DIVD_W-1:0]      divisor_i,
  output logic                                  busy_o,
  output logic [swrs_pkg::PROD_W-1:0]           quot_o,
  output logic [swrs_pkg::DIVD_W-1:0]           rem_o
);

  localparam int STEPS = swrs_pkg::PROD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0]               cnt_q;
  logic [swrs_pkg::PROD_W-1:0]    quo_q, quo_d;
  logic [swrs_pkg::DIVD_W-1:0]    rem_q, rem_d;
  logic [swrs_pkg::DIVD_W-1:0]    dvs_q;

  always_comb begin
    logic [swrs_pkg::DIVD_W:0] r;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < 2; i++) begin
      r = {rem_d, quo_d[swrs_pkg::PROD_W-1]};
      if (r >= {1'b0, dvs_q}) begin
        rem_d = swrs_pkg::DIVD_W'(r - {1'b0, dvs_q});
        quo_d = {quo_d[swrs_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_d = r[swrs_pkg::DIVD_W-1:0];
        quo_d = {quo_d[swrs_pkg::PROD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/swrs_front.sv =====
// ----------------------------------------------------------------------------
// swrs_front
// Configuration register, item intake and a two-entry queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module swrs_front #(
  parameter int FLOWS = swrs_pkg::FLOWS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [swrs_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               func_i,
  input  wire logic [swrs_pkg::FLOW_IDX_W-1:0]    flow_index_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        now_us_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        min_rate_bps_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        max_rate_bps_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        max_burst_bytes_i,
  input  wire logic [swrs_pkg::WIN_W-1:0]         window_ms_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        queue_bytes_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        alloc_min_bytes_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        alloc_max_bytes_i,
  output swrs_pkg::item_t                         q_item_o,
  output logic                                    q_valid_o,
  input  wire logic                               q_pop_i
);

  logic [swrs_pkg::FRAME_W-1:0] frame_q;
  swrs_pkg::item_t              fifo_q [2];
  swrs_pkg::item_t              new_item;
  logic                         wr_q, rd_q;
  logic [1:0]                   cnt_q;
  logic                         push;

  // the register sits at word address zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= swrs_pkg::FRAME_RST;
    end else if (psel && penable && pwrite && (paddr[2] == swrs_pkg::REG_FRAME)) begin
      frame_q <= pwdata[swrs_pkg::FRAME_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == swrs_pkg::REG_FRAME) ? 32'(frame_q) : '0;

  always_comb begin
    new_item.func     = func_i;
    new_item.in_table = (32'(flow_index_i) < 32'(FLOWS));
    new_item.idx      = flow_index_i;
    new_item.now      = now_us_i;
    new_item.rmin     = min_rate_bps_i;
    new_item.rmax     = max_rate_bps_i;
    new_item.burst    = max_burst_bytes_i;
    new_item.win      = window_ms_i;
    new_item.queue    = queue_bytes_i;
    new_item.amin     = alloc_min_bytes_i;
    new_item.amax     = alloc_max_bytes_i;
    new_item.frame    = frame_q;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= new_item;
  end

endmodule

`default_nettype wire

// ===== rtl/core/swrs_back.sv =====
// ----------------------------------------------------------------------------
// swrs_back
// Flow table and the per-item sequencer: products, sums, division, limits.
// ----------------------------------------------------------------------------
`default_nettype none

module swrs_back #(
  parameter int FLOWS = swrs_pkg::FLOWS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire swrs_pkg::item_t                q_item_i,
  input  wire logic                           q_valid_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [swrs_pkg::DATA_W-1:0]         want_min_bytes_o,
  output logic [swrs_pkg::DATA_W-1:0]         want_max_bytes_o
);

  localparam int MAXF    = 1 << swrs_pkg::FLOW_IDX_W;
  localparam int ENTRIES = (FLOWS < MAXF) ? FLOWS : MAXF;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW      = swrs_pkg::DATA_W;
  localparam int PW      = swrs_pkg::PROD_W;
  localparam int VW      = swrs_pkg::DIVD_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_GO   = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]               state_q, state_d;
  swrs_pkg::item_t          itm_q;
  logic [3*DW-1:0]          mem [ENTRIES];
  logic [3*DW-1:0]          rd_q;
  logic [ENTRIES-1:0]       valid_q;
  logic [IDX_W-1:0]         itm_idx;
  logic                     known_q;
  logic [swrs_pkg::T_W-1:0] t_q;
  logic [DW-1:0]            dt_q, tdiff_q;
  logic                     le_q;
  logic [VW-1:0]            dsum_q, divd_q;
  logic [PW-1:0]            m1_q [2];
  logic [PW-1:0]            m2_q [2];
  logic [PW-1:0]            divn_q [2];
  logic                     zero_q [2];
  logic                     ovf_q [2];
  logic [PW-1:0]            quot [2];
  logic [VW-1:0]            rem [2];
  logic                     busy [2];
  logic [DW-1:0]            res [2];
  logic [DW-1:0]            lim [2];
  logic [DW-1:0]            out_q [2];
  logic                     out_valid_q;
  logic                     is_query, fin_go;

  assign itm_idx  = itm_q.idx[IDX_W-1:0];
  assign is_query = (itm_q.func == swrs_pkg::FUNC_QUERY);
  assign fin_go   = !is_query || !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (q_valid_i) state_d = S_READ;
      S_READ: state_d = S_DIFF;
      S_DIFF: state_d = S_MUL;
      S_MUL:  state_d = S_SUM;
      S_SUM:  state_d = S_GO;
      S_GO:   state_d = S_DIV;
      S_DIV:  if (!busy[0] && !busy[1]) state_d = S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // lane 0 works on the minimum rate, lane 1 on the maximum rate
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DW-1:0]  rate, alloc, last, a1, b1, a2, b2;
    logic [PW:0]    sum;
    logic [PW:0]    rnd;
    logic [DW-1:0]  sat;
    logic           ceil_up;

    assign rate  = (l == 0) ? itm_q.rmin : itm_q.rmax;
    assign alloc = (l == 0) ? itm_q.amin : itm_q.amax;
    assign last  = rd_q[l*DW +: DW];

    always_comb begin
      if (is_query && !known_q) begin
        a1 = rate;
        b1 = DW'(itm_q.frame);
      end else if (is_query) begin
        a1 = DW'(t_q);
        b1 = rate;
      end else begin
        a1 = last;
        b1 = DW'(t_q);
      end
      if (is_query) begin
        a2 = tdiff_q;
        b2 = last;
      end else begin
        a2 = alloc;
        b2 = DW'(swrs_pkg::US_PER_BYTE);
      end
    end

    assign sum = {1'b0, m1_q[l]} + {1'b0, m2_q[l]};

    always_ff @(posedge clk_i) begin
      if (state_q == S_MUL) begin
        m1_q[l] <= PW'(a1) * PW'(b1);
        m2_q[l] <= PW'(a2) * PW'(b2);
      end
      if (state_q == S_SUM) begin
        zero_q[l] <= 1'b0;
        ovf_q[l]  <= 1'b0;
        if (is_query && !known_q) begin
          divn_q[l] <= m1_q[l];
        end else if (is_query && le_q) begin
          zero_q[l] <= (m2_q[l] >= m1_q[l]);
          divn_q[l] <= m1_q[l] - m2_q[l];
        end else if (is_query) begin
          ovf_q[l]  <= sum[PW];
          divn_q[l] <= sum[PW-1:0];
        end else if (!known_q) begin
          divn_q[l] <= m2_q[l];
        end else begin
          divn_q[l] <= sum[PW-1:0];
        end
      end
    end

    swrs_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (state_q == S_GO),
      .dividend_i (divn_q[l]),
      .divisor_i  (divd_q),
      .busy_o     (busy[l]),
      .quot_o     (quot[l]),
      .rem_o      (rem[l])
    );

    // round up for minimum-rate answers of new flows and window averages
    assign ceil_up = (l == 0) && ((is_query && !known_q) || (!is_query && known_q))
                     && (rem[l] != '0);
    assign rnd     = {1'b0, quot[l]} + (PW + 1)'(ceil_up);
    assign sat     = (rnd[PW:DW] != '0) ? '1 : rnd[DW-1:0];

    always_comb begin
      if (zero_q[l]) begin
        res[l] = '0;
      end else if (ovf_q[l]) begin
        res[l] = '1;
      end else begin
        res[l] = sat;
      end
      lim[l] = res[l];
      if (itm_q.burst < lim[l]) lim[l] = itm_q.burst;
      if (itm_q.queue < lim[l]) lim[l] = itm_q.queue;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          itm_q <= q_item_i;
          rd_q  <= mem[q_item_i.idx[IDX_W-1:0]];
        end
      end
      S_READ: begin
        t_q     <= swrs_pkg::T_W'(itm_q.win) * swrs_pkg::T_W'(swrs_pkg::US_PER_MS);
        dt_q    <= itm_q.now - rd_q[2*DW +: DW];
        known_q <= itm_q.in_table && valid_q[itm_idx];
      end
      S_DIFF: begin
        le_q    <= (DW'(t_q) >= dt_q);
        tdiff_q <= (DW'(t_q) >= dt_q) ? DW'(t_q) - dt_q : dt_q - DW'(t_q);
        dsum_q  <= VW'(t_q) + VW'(dt_q);
      end
      S_SUM: begin
        if (is_query) begin
          divd_q <= VW'(swrs_pkg::US_PER_BYTE);
        end else if (!known_q) begin
          divd_q <= (itm_q.frame == '0) ? VW'(1) : VW'(itm_q.frame);
        end else begin
          divd_q <= (dsum_q == '0) ? VW'(1) : dsum_q;
        end
      end
      S_FIN: begin
        if (is_query && fin_go) begin
          out_q[0] <= lim[0];
          out_q[1] <= lim[1];
        end else if (!is_query && itm_q.in_table) begin
          mem[itm_idx] <= {itm_q.now, res[1], res[0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && is_query && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_FIN && !is_query && itm_q.in_table) begin
        valid_q[itm_idx] <= 1'b1;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign want_min_bytes_o = out_q[0];
  assign want_max_bytes_o = out_q[1];

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_rate_shaper_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_rate_shaper_unit
// Per-flow sliding-window rate estimator: answers wanted byte sizes for a
// query, folds allocated bytes into the window average for a report.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// config    in/out     psel/penable/pready     paddr, pwdata, prdata
// items     in         in_valid_i/in_stall_o   func_i .. alloc_max_bytes_i
// results   out        out_valid_o/out_stall_i want_min_bytes_o, want_max_bytes_o
//
// An item passes back-end states read, diff, mul, sum and go, 32 steps of
// the two-bit-per-cycle dividers (one per rate lane) and a finish state held
// by a stalled result. A two-entry queue lets the input take items meanwhile.
// Reset clears the flow valid bits at once; no clearing pass is needed.
// A query result waits in the output register while out_stall_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rate_shaper_unit #(
  parameter int FLOWS = swrs_pkg::FLOWS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [swrs_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               func_i,
  input  wire logic [swrs_pkg::FLOW_IDX_W-1:0]    flow_index_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        now_us_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        min_rate_bps_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        max_rate_bps_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        max_burst_bytes_i,
  input  wire logic [swrs_pkg::WIN_W-1:0]         window_ms_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        queue_bytes_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        alloc_min_bytes_i,
  input  wire logic [swrs_pkg::DATA_W-1:0]        alloc_max_bytes_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [swrs_pkg::DATA_W-1:0]             want_min_bytes_o,
  output logic [swrs_pkg::DATA_W-1:0]             want_max_bytes_o
);

  swrs_pkg::item_t q_item;
  logic            q_valid, q_pop;

  swrs_front #(.FLOWS(FLOWS)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .flow_index_i      (flow_index_i),
    .now_us_i          (now_us_i),
    .min_rate_bps_i    (min_rate_bps_i),
    .max_rate_bps_i    (max_rate_bps_i),
    .max_burst_bytes_i (max_burst_bytes_i),
    .window_ms_i       (window_ms_i),
    .queue_bytes_i     (queue_bytes_i),
    .alloc_min_bytes_i (alloc_min_bytes_i),
    .alloc_max_bytes_i (alloc_max_bytes_i),
    .q_item_o          (q_item),
    .q_valid_o         (q_valid),
    .q_pop_i           (q_pop)
  );

  swrs_back #(.FLOWS(FLOWS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_item_i         (q_item),
    .q_valid_i        (q_valid),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .want_min_bytes_o (want_min_bytes_o),
    .want_max_bytes_o (want_max_bytes_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for sliding_window_rate_shaper_unit. Items are driven with random
// gaps, and results are taken with random stalls and one long hold-off. A
// predictor keeps its own copy of the flow table and frame duration. Every
// query result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam logic [swrs_pkg::ADDR_W-1:0] ADDR_FRAME  = 3'd0;
  localparam logic [swrs_pkg::ADDR_W-1:0] ADDR_UNUSED = 3'd4;
  localparam longint unsigned BYTE_US = 64'd8000000;

  typedef struct {
    logic        func;
    logic [5:0]  flow;
    logic [31:0] now;
    logic [31:0] rmin;
    logic [31:0] rmax;
    logic [31:0] burst;
    logic [15:0] win;
    logic [31:0] queue;
    logic [31:0] amin;
    logic [31:0] amax;
  } shaper_item_t;

  typedef struct {
    logic [31:0] want_min;
    logic [31:0] want_max;
  } want_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [swrs_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  shaper_item_t drv = '{default: '0};
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] want_min_bytes_o, want_max_bytes_o;

  // predictor state
  logic [19:0] frame_us = swrs_pkg::FRAME_RST;
  logic        flow_known [64];
  logic [31:0] flow_min_rate [64];
  logic [31:0] flow_max_rate [64];
  logic [31:0] flow_stamp [64];
  want_t       want_q [$];

  int unsigned items_taken, wants_seen, errors, idle_cycles;
  int unsigned n_queries, n_reports, frames_used;
  int unsigned hold_cycles, stall_left;
  bit          rand_stall;
  logic [31:0] clock_us;

  sliding_window_rate_shaper_unit u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .func_i(drv.func), .flow_index_i(drv.flow), .now_us_i(drv.now),
    .min_rate_bps_i(drv.rmin), .max_rate_bps_i(drv.rmax),
    .max_burst_bytes_i(drv.burst), .window_ms_i(drv.win), .queue_bytes_i(drv.queue),
    .alloc_min_bytes_i(drv.amin), .alloc_max_bytes_i(drv.amax),
    .out_valid_o, .out_stall_i, .want_min_bytes_o, .want_max_bytes_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] sat32(logic [127:0] v);
    return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] min3(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // bytes from (T*rate - (T-dt)*last) / 8e6, clamped at 0
  function automatic logic [31:0] window_want(logic [127:0] t, logic [127:0] dt,
                                              logic [127:0] rate, logic [127:0] last);
    logic [127:0] a, b;
    a = t * rate;
    if (dt <= t) begin
      b = (t - dt) * last;
      if (b >= a) return 32'd0;
      return sat32((a - b) / BYTE_US);
    end
    return sat32((a + (dt - t) * last) / BYTE_US);
  endfunction

  function automatic void predict_item(shaper_item_t it);
    logic [127:0] t, dt, d, f, nmin, nmax, pmin, pmax;
    logic [31:0]  wmin, wmax, dt32;
    int           i;
    i    = it.flow;
    t    = 128'(it.win) * 128'd1000;
    dt32 = it.now - flow_stamp[i];
    dt   = 128'(dt32);
    if (it.func == swrs_pkg::FUNC_REPORT) begin
      n_reports++;
      if (!flow_known[i]) begin
        f = (frame_us == 0) ? 128'd1 : 128'(frame_us);
        flow_min_rate[i] = sat32(128'(it.amin) * BYTE_US / f);
        flow_max_rate[i] = sat32(128'(it.amax) * BYTE_US / f);
        flow_known[i] = 1'b1;
      end else begin
        d = t + dt;
        if (d == 0) d = 128'd1;
        nmin = 128'(flow_min_rate[i]) * t + 128'(it.amin) * BYTE_US;
        nmax = 128'(flow_max_rate[i]) * t + 128'(it.amax) * BYTE_US;
        flow_min_rate[i] = sat32(nmin / d + ((nmin % d != 0) ? 128'd1 : 128'd0));
        flow_max_rate[i] = sat32(nmax / d);
      end
      flow_stamp[i] = it.now;
      return;
    end
    n_queries++;
    if (!flow_known[i]) begin
      pmin = 128'(it.rmin) * 128'(frame_us);
      pmax = 128'(it.rmax) * 128'(frame_us);
      wmin = sat32(pmin / BYTE_US + ((pmin % BYTE_US != 0) ? 128'd1 : 128'd0));
      wmax = sat32(pmax / BYTE_US);
    end else begin
      wmin = window_want(t, dt, 128'(it.rmin), 128'(flow_min_rate[i]));
      wmax = window_want(t, dt, 128'(it.rmax), 128'(flow_max_rate[i]));
    end
    want_q.push_back('{min3(wmin, it.burst, it.queue), min3(wmax, it.burst, it.queue)});
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp, wants_seen);
    errors++;
  endtask

  // item monitor and result checker
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_item(drv);
      items_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      wants_seen++;
      stall_left = rand_stall ? $urandom_range(0, 19) : 0;
      if (want_q.size() == 0) begin
        report_mismatch("unexpected result", want_min_bytes_o, 32'd0);
      end else begin
        if (want_min_bytes_o !== want_q[0].want_min)
          report_mismatch("want_min_bytes", want_min_bytes_o, want_q[0].want_min);
        if (want_max_bytes_o !== want_q[0].want_max)
          report_mismatch("want_max_bytes", want_max_bytes_o, want_q[0].want_max);
        void'(want_q.pop_front());
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: long hold-off first, then per-result stall
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // entered and left at a falling edge
  task automatic send_item(shaper_item_t it, bit no_gap = 0);
    int unsigned gap, target;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    target = items_taken + 1;
    drv = it;
    in_valid_i = 1'b1;
    do @(negedge clk_i); while (items_taken < target);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (want_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [swrs_pkg::ADDR_W-1:0] addr, logic [31:0] data);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_FRAME) begin
      frame_us = data[19:0];
      frames_used++;
    end
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return $urandom_range(0, 1000);
      3: return $urandom_range(0, 2000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic shaper_item_t noise_item();
    shaper_item_t it;
    it = '{1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), $urandom, $urandom,
           $urandom, $urandom, 16'($urandom_range(0, 65535)), $urandom, $urandom,
           $urandom};
    return it;
  endfunction

  // plausible traffic: few flows, advancing clock, modest windows
  function automatic shaper_item_t flow_item();
    shaper_item_t it;
    it = noise_item();
    it.flow  = 6'($urandom_range(0, 7));
    clock_us = clock_us + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6000));
    it.now   = clock_us;
    it.rmin  = pick32();
    it.rmax  = pick32();
    it.burst = ($urandom_range(0, 2) == 0) ? pick32() : 32'hFFFF_FFFF;
    it.queue = ($urandom_range(0, 2) == 0) ? pick32() : 32'hFFFF_FFFF;
    it.win   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
    it.amin  = pick32();
    it.amax  = pick32();
    return it;
  endfunction

  function automatic shaper_item_t mk(logic func, logic [5:0] flow, logic [31:0] now,
                                      logic [31:0] r, logic [15:0] win, logic [31:0] a);
    shaper_item_t it;
    it = '{func, flow, now, r, r, 32'hFFFF_FFFF, win, 32'hFFFF_FFFF, a, a};
    return it;
  endfunction

  task automatic test_directed();
    shaper_item_t it;
    // unknown flow, extremes of rate and limits
    send_item(mk(swrs_pkg::FUNC_QUERY, 6'd63, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0));
    send_item(mk(swrs_pkg::FUNC_QUERY, 6'd0, 32'hFFFF_FFFF, 32'd0, 16'd0, 32'hFFFF_FFFF));
    it = mk(swrs_pkg::FUNC_QUERY, 6'd5, 32'd7, 32'd12345678, 16'd10, 32'd0);
    it.burst = 32'd100;
    send_item(it);
    it.burst = 32'hFFFF_FFFF; it.queue = 32'd3;
    send_item(it);
    // create, then queries inside and beyond the window
    send_item(mk(swrs_pkg::FUNC_REPORT, 6'd1, 32'd1000, 32'd0, 16'd10, 32'd5000));
    send_item(mk(swrs_pkg::FUNC_QUERY, 6'd1, 32'd3000, 32'd8000000, 16'd10, 32'd0));
    send_item(mk(swrs_pkg::FUNC_QUERY, 6'd1, 32'd50000, 32'd8000000, 16'd10, 32'd0));
    // negative window result clamps to 0
    send_item(mk(swrs_pkg::FUNC_QUERY, 6'd1, 32'd1000, 32'd0, 16'd10, 32'd0));
    // wrapped elapsed time
    send_item(mk(swrs_pkg::FUNC_QUERY, 6'd1, 32'd500, 32'hFFFF_FFFF, 16'hFFFF, 32'd0));
    // zero window and zero elapsed time on a known flow
    send_item(mk(swrs_pkg::FUNC_REPORT, 6'd1, 32'd1000, 32'd0, 16'd0, 32'd777));
    send_item(mk(swrs_pkg::FUNC_REPORT, 6'd1, 32'd1000, 32'd0, 16'd0, 32'hFFFF_FFFF));
    send_item(mk(swrs_pkg::FUNC_QUERY, 6'd1, 32'd1000, 32'hFFFF_FFFF, 16'hFFFF, 32'd0));
    // saturating rate on create
    send_item(mk(swrs_pkg::FUNC_REPORT, 6'd63, 32'hFFFF_FFFF, 32'd0, 16'hFFFF,
                 32'hFFFF_FFFF));
    send_item(mk(swrs_pkg::FUNC_REPORT, 6'd63, 32'd5, 32'd0, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk(swrs_pkg::FUNC_QUERY, 6'd63, 32'd6, 32'hFFFF_FFFF, 16'hFFFF, 32'd0));
    send_item(mk(swrs_pkg::FUNC_QUERY, 6'd63, 32'hFFFF_0000, 32'd0, 16'd1, 32'd0));
    settle();
  endtask

  task automatic test_frames();
    logic [31:0] frames [5];
    frames = '{32'd1, 32'd1000000, 32'd0, 32'h000F_FFFF, 32'hFFF0_1388};
    foreach (frames[k]) begin
      write_reg(ADDR_FRAME, frames[k]);
      write_reg(ADDR_UNUSED, $urandom);
      // fresh flows so the unknown path sees this frame
      for (int n = 0; n < 4; n++) begin
        send_item(mk(swrs_pkg::FUNC_QUERY, 6'(40 + k * 4 + n), $urandom, pick32(),
                     16'd5, 32'd0));
        send_item(mk(swrs_pkg::FUNC_REPORT, 6'(40 + k * 4 + n), $urandom, 32'd0,
                     16'd5, pick32()));
      end
      settle();
    end
    write_reg(ADDR_FRAME, 32'd5000);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 350 == 349) begin
        settle();
        write_reg(ADDR_FRAME, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 20000));
      end
      send_item(($urandom_range(0, 9) == 0) ? noise_item() : flow_item());
    end
    settle();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int n = 0; n < 12; n++) begin
      shaper_item_t it;
      it = flow_item();
      it.func = swrs_pkg::FUNC_QUERY;
      send_item(it, 1);
    end
    settle();
  endtask

  initial begin
    foreach (flow_known[i]) begin
      flow_known[i] = 1'b0;
      flow_stamp[i] = '0;
      flow_min_rate[i] = '0;
      flow_max_rate[i] = '0;
    end
    clock_us = $urandom;
    rand_stall = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    rand_stall = 1'b1;
    test_frames();
    test_backpressure();
    test_random(1450);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d items (%0d queries, %0d reports), %0d results checked",
             items_taken, n_queries, n_reports, wants_seen);
    $display("frame duration set %0d times, incl. zero and full range", frames_used);
    if (errors == 0 && want_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors, %0d results missing", errors, want_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
